### rtl/abb_pkg.sv
// ============================================================================
// Arc bounding box package
// Shared widths, angle constants, the quarter-wave sine table and the
// saturation and compare helpers used by the arc bounding box pipeline.
// ============================================================================
`default_nettype none

package abb_pkg;

    localparam int COORD_W            = 32;
    localparam int RADIUS_W           = 24;
    localparam int START_W            = 10;
    localparam int SPAN_W             = 9;
    localparam int DEG_W              = 9;
    localparam int IDX_W              = 7;
    localparam int SINE_W             = 16;
    localparam int TABLE_FRAC_BITS    = 15;
    localparam int SINE_FRAC_BITS_DEF = 15;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 128;

    localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
    localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
    localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
    localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360);

    // round(sin(d degrees) * 2^15) for d = 0 .. 90.
    localparam logic [SINE_W-1:0] QUARTER_SINE [91] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W+1:0] coord_wide_t;

    // Load enables of the two register stages inside a coordinate unit.
    typedef struct packed {
        logic mul;
        logic add;
    } coord_en_t;

    function automatic coord_t sat_coord(input coord_wide_t v);
        coord_wide_t hi;
        coord_wide_t lo;
        hi = $signed({3'b000, {(COORD_W-1){1'b1}}});
        lo = $signed({3'b111, {(COORD_W-1){1'b0}}});
        if (v > hi)
            return coord_t'(hi[COORD_W-1:0]);
        else if (v < lo)
            return coord_t'(lo[COORD_W-1:0]);
        else
            return coord_t'(v[COORD_W-1:0]);
    endfunction

    function automatic coord_t min_coord(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t max_coord(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

### rtl/abb_coord.sv
// ============================================================================
// Arc bounding box coordinate unit
// Two register stages: radius times trig magnitude, then rounding, sign,
// centre offset and saturation to the Q24.8 range.
// ============================================================================
`default_nettype none

module abb_coord
    import abb_pkg::*;
#(
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF,
    parameter int TRIG_W         = SINE_FRAC_BITS + 1
)
(
    input  logic                clk,
    input  coord_en_t           en,
    input  logic [RADIUS_W-1:0] radius,
    input  logic [TRIG_W-1:0]   trig,
    input  logic                neg,
    input  coord_t              centre,
    output coord_t              point
);

    localparam int PROD_W = RADIUS_W + TRIG_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SINE_FRAC_BITS - 1);

    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;
    coord_t              centre_reg;
    coord_t              point_reg;

    logic [PROD_W-1:0]   prod_next;
    logic [PROD_W-1:0]   rounded;
    logic [RADIUS_W-1:0] mag;
    coord_wide_t         mag_s;
    coord_wide_t         sum_next;

    assign prod_next = PROD_W'(radius) * PROD_W'(trig);

    always_comb
    begin
        rounded  = prod_reg + ROUND_HALF;
        mag      = rounded[SINE_FRAC_BITS +: RADIUS_W];
        mag_s    = $signed({{(COORD_W+2-RADIUS_W){1'b0}}, mag});
        sum_next = $signed({{2{centre_reg[COORD_W-1]}}, centre_reg})
                   + (neg_reg ? -mag_s : mag_s);
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg   <= prod_next;
            neg_reg    <= neg;
            centre_reg <= centre;
        end
        if (en.add)
        begin
            point_reg <= sat_coord(sum_next);
        end
    end

    assign point = point_reg;

endmodule

`default_nettype wire

### rtl/arc_bounding_box.sv
// ============================================================================
// Arc bounding box
// Axis-aligned bounding box of a circular arc, eight-stage pipeline.
// ============================================================================
// Usage: each beat on the s_axis channel is one arc (centre, radius, start
// angle and counterclockwise span in whole degrees). For every accepted beat
// exactly one beat leaves on m_axis carrying the arc's box: top, left, bottom
// and right in signed Q24.8, saturated to the 32-bit range.
// The box covers both endpoints and every axis direction that the arc
// passes through. Endpoint cos and sin come from a whole-degree quarter-wave
// sine table; the axis points are simply the centre plus or minus the radius.
// Throughput is one arc per cycle while the receiver is ready: every stage has
// its own valid bit and takes a new beat whenever it is empty or its
// successor moves on, so the four radius multipliers in the coordinate
// units are each used once per beat and never shared.
// When the receiver stalls, full stages hold their beats and bubbles in
// front of them still close up; s_axis_tready falls only once all eight
// stages are full. Nothing is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset and there
// is no clearing pass, so it accepts a beat in the first cycle after reset.
// ============================================================================
`default_nettype none

module arc_bounding_box
    import abb_pkg::*;
#(
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // center_x[31:0], center_y[63:32], radius[87:64], start_angle[97:88],
    // span_angle[106:98], zero padding [111:107]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // top[31:0], left[63:32], bottom[95:64], right[127:96]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int TRIG_W     = SINE_FRAC_BITS + 1;
    localparam int STAGES     = 8;
    localparam int UP_SHIFT   = (SINE_FRAC_BITS > TABLE_FRAC_BITS) ?
                                SINE_FRAC_BITS - TABLE_FRAC_BITS : 0;
    localparam int DOWN_SHIFT = (SINE_FRAC_BITS < TABLE_FRAC_BITS) ?
                                TABLE_FRAC_BITS - SINE_FRAC_BITS : 0;
    localparam int ROUND_ADD  = (SINE_FRAC_BITS < TABLE_FRAC_BITS) ?
                                (1 << (DOWN_SHIFT - 1)) : 0;

    localparam logic signed [START_W:0] START_360 = (START_W+1)'(360);
    localparam logic signed [START_W:0] START_720 = (START_W+1)'(720);
    localparam logic signed [START_W:0] START_NEG_360 = -START_360;

    localparam logic [IDX_W-1:0] IDX_90 = IDX_W'(DEG_90);

    // Quadrant codes of an angle in 0 .. 359.
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    localparam logic [DEG_W:0] AXIS_DEG [4] = '{
        '0, (DEG_W+1)'(DEG_90), (DEG_W+1)'(DEG_180), (DEG_W+1)'(DEG_270)
    };

    typedef struct packed {
        logic [1:0]       quad;
        logic [IDX_W-1:0] rem;
    } quad_t;

    function automatic quad_t split_angle(input logic [DEG_W-1:0] a);
        quad_t res;
        priority if (a >= DEG_270)
        begin
            res.quad = QUAD_IV;
            res.rem  = IDX_W'(a - DEG_270);
        end
        else if (a >= DEG_180)
        begin
            res.quad = QUAD_III;
            res.rem  = IDX_W'(a - DEG_180);
        end
        else if (a >= DEG_90)
        begin
            res.quad = QUAD_II;
            res.rem  = IDX_W'(a - DEG_90);
        end
        else
        begin
            res.quad = QUAD_I;
            res.rem  = IDX_W'(a);
        end
        return res;
    endfunction

    // Table entry rescaled to SINE_FRAC_BITS fraction bits.
    function automatic logic [TRIG_W-1:0] scale_sine(input logic [IDX_W-1:0] idx);
        logic [SINE_W-1:0] t;
        logic [SINE_W:0]   rounded;
        t       = QUARTER_SINE[idx];
        rounded = {1'b0, t} + (SINE_W+1)'(ROUND_ADD);
        if (SINE_FRAC_BITS < TABLE_FRAC_BITS)
            return TRIG_W'(rounded >> DOWN_SHIFT);
        else
            return TRIG_W'(t) << UP_SHIFT;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage loads when it is empty or its successor
    // is loading, so bubbles close up under a stall.
    // ------------------------------------------------------------------
    logic [STAGES:1]   valid_reg;
    logic [STAGES+1:1] stage_en;
    logic [STAGES:1]   valid_in;

    always_comb
    begin
        stage_en[STAGES+1] = m_axis_tready;
        for (int k = STAGES; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign valid_in = {valid_reg[STAGES-1:1], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                if (stage_en[k])
                    valid_reg[k] <= valid_in[k];
            end
        end
    end

    assign s_axis_tready = stage_en[1];
    assign m_axis_tvalid = valid_reg[STAGES];

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    coord_t                     center_x;
    coord_t                     center_y;
    logic [RADIUS_W-1:0]        radius;
    logic signed [START_W-1:0]  start_angle;
    logic [SPAN_W-1:0]          span_angle;

    assign center_x    = coord_t'(s_axis_tdata[31:0]);
    assign center_y    = coord_t'(s_axis_tdata[63:32]);
    assign radius      = s_axis_tdata[87:64];
    assign start_angle = $signed(s_axis_tdata[97:88]);
    assign span_angle  = s_axis_tdata[106:98];

    // ------------------------------------------------------------------
    // Stage 1: start angle reduced to 0 .. 359, span clamped to 360.
    // ------------------------------------------------------------------
    coord_t              cx1_reg, cy1_reg;
    logic [RADIUS_W-1:0] r1_reg;
    logic [DEG_W-1:0]    a0_1_reg, a0_next;
    logic [SPAN_W-1:0]   span1_reg, span_next;
    logic signed [START_W:0] start_ext, start_wrap;

    always_comb
    begin
        start_ext = {start_angle[START_W-1], start_angle};
        if (start_ext < START_NEG_360)
            start_wrap = start_ext + START_720;
        else if (start_ext < 0)
            start_wrap = start_ext + START_360;
        else if (start_ext >= START_360)
            start_wrap = start_ext - START_360;
        else
            start_wrap = start_ext;
        a0_next   = start_wrap[DEG_W-1:0];
        span_next = (span_angle > SPAN_W'(DEG_360)) ? SPAN_W'(DEG_360) : span_angle;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            cx1_reg   <= center_x;
            cy1_reg   <= center_y;
            r1_reg    <= radius;
            a0_1_reg  <= a0_next;
            span1_reg <= span_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: end angle, and which axis directions the arc reaches.
    // ------------------------------------------------------------------
    coord_t              cx2_reg, cy2_reg;
    logic [RADIUS_W-1:0] r2_reg;
    logic [DEG_W-1:0]    a0_2_reg, end2_reg, end_next;
    logic [3:0]          axis2_reg, axis_next;
    logic [DEG_W:0]      end_sum;
    logic [DEG_W:0]      axis_dist [4];

    always_comb
    begin
        end_sum  = {1'b0, a0_1_reg} + (DEG_W+1)'(span1_reg);
        end_next = (end_sum >= (DEG_W+1)'(DEG_360)) ?
                   DEG_W'(end_sum - (DEG_W+1)'(DEG_360)) : DEG_W'(end_sum);
        for (int k = 0; k < 4; k++)
        begin
            if ({1'b0, a0_1_reg} <= AXIS_DEG[k])
                axis_dist[k] = AXIS_DEG[k] - {1'b0, a0_1_reg};
            else
                axis_dist[k] = AXIS_DEG[k] + (DEG_W+1)'(DEG_360) - {1'b0, a0_1_reg};
            axis_next[k] = axis_dist[k] <= (DEG_W+1)'(span1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            r2_reg    <= r1_reg;
            a0_2_reg  <= a0_1_reg;
            end2_reg  <= end_next;
            axis2_reg <= axis_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quadrant split of both endpoints into table index and sign.
    // Cos of a is sin of a + 90, one quadrant further on.
    // ------------------------------------------------------------------
    coord_t              cx3_reg, cy3_reg;
    logic [RADIUS_W-1:0] r3_reg;
    logic [3:0]          axis3_reg;
    logic [IDX_W-1:0]    sin_idx_reg [2];
    logic [IDX_W-1:0]    cos_idx_reg [2];
    logic                sin_neg_reg [2];
    logic                cos_neg_reg [2];
    quad_t               split_next  [2];

    assign split_next[0] = split_angle(a0_2_reg);
    assign split_next[1] = split_angle(end2_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            r3_reg    <= r2_reg;
            axis3_reg <= axis2_reg;
            for (int p = 0; p < 2; p++)
            begin
                sin_idx_reg[p] <= split_next[p].quad[0] ?
                                  IDX_90 - split_next[p].rem : split_next[p].rem;
                cos_idx_reg[p] <= split_next[p].quad[0] ?
                                  split_next[p].rem : IDX_90 - split_next[p].rem;
                sin_neg_reg[p] <= split_next[p].quad[1];
                cos_neg_reg[p] <= split_next[p].quad[1] ^ split_next[p].quad[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: table read and rescale.
    // ------------------------------------------------------------------
    coord_t              cx4_reg, cy4_reg;
    logic [RADIUS_W-1:0] r4_reg;
    logic [3:0]          axis4_reg;
    logic [TRIG_W-1:0]   sin_reg [2];
    logic [TRIG_W-1:0]   cos_reg [2];
    logic                sin_neg4_reg [2];
    logic                cos_neg4_reg [2];

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            cx4_reg   <= cx3_reg;
            cy4_reg   <= cy3_reg;
            r4_reg    <= r3_reg;
            axis4_reg <= axis3_reg;
            for (int p = 0; p < 2; p++)
            begin
                sin_reg[p]      <= scale_sine(sin_idx_reg[p]);
                cos_reg[p]      <= scale_sine(cos_idx_reg[p]);
                sin_neg4_reg[p] <= sin_neg_reg[p];
                cos_neg4_reg[p] <= cos_neg_reg[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 and 6: endpoint coordinates in the four coordinate units.
    // ------------------------------------------------------------------
    coord_en_t coord_en;
    coord_t    end_x [2];
    coord_t    end_y [2];

    assign coord_en.mul = stage_en[5];
    assign coord_en.add = stage_en[6];

    for (genvar p = 0; p < 2; p++)
    begin : g_endpoint
        abb_coord #(
            .SINE_FRAC_BITS (SINE_FRAC_BITS),
            .TRIG_W         (TRIG_W)
        ) u_coord_x (
            .clk    (clk),
            .en     (coord_en),
            .radius (r4_reg),
            .trig   (cos_reg[p]),
            .neg    (cos_neg4_reg[p]),
            .centre (cx4_reg),
            .point  (end_x[p])
        );

        abb_coord #(
            .SINE_FRAC_BITS (SINE_FRAC_BITS),
            .TRIG_W         (TRIG_W)
        ) u_coord_y (
            .clk    (clk),
            .en     (coord_en),
            .radius (r4_reg),
            .trig   (sin_reg[p]),
            .neg    (sin_neg4_reg[p]),
            .centre (cy4_reg),
            .point  (end_y[p])
        );
    end

    // The centre, radius and axis flags run alongside; the axis points are
    // formed in stage 6 because the full-scale table entry is exact.
    coord_t              cx5_reg, cy5_reg;
    logic [RADIUS_W-1:0] r5_reg;
    logic [3:0]          axis5_reg;
    coord_t              cx6_reg, cy6_reg;
    coord_t              xp6_reg, xn6_reg, yp6_reg, yn6_reg;
    logic [3:0]          axis6_reg;
    coord_wide_t         cx5_w, cy5_w, r5_w;

    assign cx5_w = $signed({{2{cx5_reg[COORD_W-1]}}, cx5_reg});
    assign cy5_w = $signed({{2{cy5_reg[COORD_W-1]}}, cy5_reg});
    assign r5_w  = $signed({{(COORD_W+2-RADIUS_W){1'b0}}, r5_reg});

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            cx5_reg   <= cx4_reg;
            cy5_reg   <= cy4_reg;
            r5_reg    <= r4_reg;
            axis5_reg <= axis4_reg;
        end
        if (stage_en[6])
        begin
            cx6_reg   <= cx5_reg;
            cy6_reg   <= cy5_reg;
            xp6_reg   <= sat_coord(cx5_w + r5_w);
            xn6_reg   <= sat_coord(cx5_w - r5_w);
            yp6_reg   <= sat_coord(cy5_w + r5_w);
            yn6_reg   <= sat_coord(cy5_w - r5_w);
            axis6_reg <= axis5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: candidates that do not apply are replaced by the start
    // point, then compared in pairs. Stage 8 settles each extreme.
    // ------------------------------------------------------------------
    coord_t maxx_a_reg, maxx_b_reg, minx_a_reg, minx_b_reg;
    coord_t maxy_a_reg, maxy_b_reg, miny_a_reg, miny_b_reg;
    coord_t cand_xp, cand_xn, cand_yp, cand_yn, cand_cx, cand_cy;
    coord_t top_reg, left_reg, bottom_reg, right_reg;

    always_comb
    begin
        cand_xp = axis6_reg[0] ? xp6_reg : end_x[0];
        cand_xn = axis6_reg[2] ? xn6_reg : end_x[0];
        cand_yp = axis6_reg[1] ? yp6_reg : end_y[0];
        cand_yn = axis6_reg[3] ? yn6_reg : end_y[0];
        cand_cx = (axis6_reg[1] || axis6_reg[3]) ? cx6_reg : end_x[0];
        cand_cy = (axis6_reg[0] || axis6_reg[2]) ? cy6_reg : end_y[0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            maxx_a_reg <= max_coord(end_x[0], end_x[1]);
            maxx_b_reg <= max_coord(cand_xp, cand_cx);
            minx_a_reg <= min_coord(end_x[0], end_x[1]);
            minx_b_reg <= min_coord(cand_xn, cand_cx);
            maxy_a_reg <= max_coord(end_y[0], end_y[1]);
            maxy_b_reg <= max_coord(cand_yp, cand_cy);
            miny_a_reg <= min_coord(end_y[0], end_y[1]);
            miny_b_reg <= min_coord(cand_yn, cand_cy);
        end
        if (stage_en[8])
        begin
            top_reg    <= max_coord(maxy_a_reg, maxy_b_reg);
            left_reg   <= min_coord(minx_a_reg, minx_b_reg);
            bottom_reg <= min_coord(miny_a_reg, miny_b_reg);
            right_reg  <= max_coord(maxx_a_reg, maxx_b_reg);
        end
    end

    assign m_axis_tdata = {right_reg, bottom_reg, left_reg, top_reg};

`ifndef SYNTH
    a_start_reduced : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (a0_1_reg < DEG_360) && (span1_reg <= SPAN_W'(DEG_360)))
        else $error("reduced start angle or clamped span out of range");

    a_end_reduced : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (end2_reg < DEG_360))
        else $error("end angle out of range");

    a_full_circle : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && span1_reg == SPAN_W'(DEG_360)) && stage_en[2]
        |=> (axis2_reg == 4'hF))
        else $error("full circle missed an axis direction");

    a_box_ordered : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (bottom_reg <= top_reg) && (left_reg <= right_reg))
        else $error("bounding box edges out of order");

    a_empty_takes : assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[1] |-> s_axis_tready)
        else $error("empty first stage refused an input beat");
`endif

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Arc bounding box testbench
// Streams arcs into arc_bounding_box and checks every returned box, field by
// field, against a hand-worked box or a fixed-point predictor of the arc's axis-aligned bounds.
// A short table covers extremes and corner cases. Random arcs follow, with
// bursty input, a patterned output stall and one long output stall.
// ============================================================================
module tb;
    import abb_pkg::*;

    // Quiet cycles tolerated before the run is declared hung. The slowest
    // correct stretch is the long output stall plus a sender gap.
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 60;
    localparam int RANDOM_ARCS  = 530;
    localparam int DRAIN_CYCLES = 24;
    localparam int PRINT_LIMIT  = 40;

    // The predictor works at the table's own precision, which is what the
    // block uses when its sine width is left at the default.
    localparam int TRIG_FRAC    = SINE_FRAC_BITS_DEF;
    localparam int QUARTER_TURN = int'(DEG_90);
    localparam int FULL_TURN    = int'(DEG_360);

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    typedef struct {
        coord_t                    cx;
        coord_t                    cy;
        logic [RADIUS_W-1:0]       radius;
        logic signed [START_W-1:0] start;
        logic [SPAN_W-1:0]         span;
    } arc_t;

    typedef struct {
        coord_t top;
        coord_t left;
        coord_t bottom;
        coord_t right;
    } box_t;

    // One line of the directed table. Where known is set the box was worked
    // out by hand and is checked as typed; otherwise the predictor fills it.
    typedef struct {
        arc_t arc;
        bit   known;
        box_t box;
    } row_t;

    // Output stall patterns, each kept for a random number of cycles.
    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_ONE_IN_FOUR,
        RX_SPARSE
    } rx_mode_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    box_t expected_boxes[$];
    row_t arc_table[$];

    int  mismatches    = 0;
    int  boxes_checked = 0;
    int  arcs_sent     = 0;
    int  full_circles  = 0;
    int  zero_spans    = 0;
    int  clamped_spans = 0;
    int  input_stalls  = 0;
    int  held_stalls   = 0;
    int  burst_left    = 0;
    bit  hold_on       = 1'b0;
    bit  hold_done     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    arc_bounding_box DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Sine of a whole-degree angle in 0..359, folded onto the quarter table.
    function automatic longint sine_of_deg(input int deg);
        int     quad;
        int     rem;
        longint mag;
        quad = deg / QUARTER_TURN;
        rem  = deg % QUARTER_TURN;
        if (quad == 1 || quad == 3)
            rem = QUARTER_TURN - rem;
        mag = longint'(QUARTER_SINE[rem]);
        return (quad >= 2) ? -mag : mag;
    endfunction

    // Centre plus radius times trig. The magnitude of the product is rounded
    // half up before the sign goes back on, so rounding is symmetric about
    // zero. The sum saturates to the Q24.8 range.
    function automatic coord_t arc_coord(input coord_t centre,
                                         input logic [RADIUS_W-1:0] radius,
                                         input longint trig);
        longint mag;
        longint p;
        mag = longint'(radius) * ((trig < 0) ? -trig : trig);
        mag = (mag + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        p   = longint'(centre) + ((trig < 0) ? -mag : mag);
        if (p > COORD_MAX)
            p = COORD_MAX;
        else if (p < COORD_MIN)
            p = COORD_MIN;
        return p[COORD_W-1:0];
    endfunction

    // Bounding box over both endpoints and every axis direction the arc
    // sweeps through. An axis direction that sits exactly on an endpoint is
    // simply evaluated twice.
    function automatic box_t arc_box(input arc_t a);
        int     span;
        int     a0;
        int     n;
        int     k;
        int     i;
        int     pts[6];
        coord_t x;
        coord_t y;
        box_t   b;
        span = int'(a.span);
        if (span > FULL_TURN)
            span = FULL_TURN;
        a0     = ((int'(a.start) % FULL_TURN) + FULL_TURN) % FULL_TURN;
        pts[0] = a0;
        pts[1] = (a0 + span) % FULL_TURN;
        n      = 2;
        for (k = 0; k < 4; k++)
        begin
            if (((k * QUARTER_TURN - a0 + 2 * FULL_TURN) % FULL_TURN) <= span)
            begin
                pts[n] = k * QUARTER_TURN;
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            x = arc_coord(a.cx, a.radius, sine_of_deg((pts[i] + QUARTER_TURN) % FULL_TURN));
            y = arc_coord(a.cy, a.radius, sine_of_deg(pts[i]));
            if (i == 0 || x < b.left)   b.left   = x;
            if (i == 0 || x > b.right)  b.right  = x;
            if (i == 0 || y < b.bottom) b.bottom = y;
            if (i == 0 || y > b.top)    b.top    = y;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_row(input longint cx, input longint cy, input int radius,
                           input int start, input int span, input bit known,
                           input longint top = 0, input longint left = 0,
                           input longint bottom = 0, input longint right = 0);
        row_t row;
        row.arc.cx     = coord_t'(cx);
        row.arc.cy     = coord_t'(cy);
        row.arc.radius = RADIUS_W'(radius);
        row.arc.start  = START_W'(start);
        row.arc.span   = SPAN_W'(span);
        row.known      = known;
        row.box.top    = coord_t'(top);
        row.box.left   = coord_t'(left);
        row.box.bottom = coord_t'(bottom);
        row.box.right  = coord_t'(right);
        arc_table.push_back(row);
    endtask

    // Mostly modest coordinates, some fully random and some close to either
    // rail so that the saturation on both sides gets exercised.
    function automatic coord_t pick_coord();
        int     pick;
        longint off;
        pick = $urandom_range(0, 99);
        off  = longint'($urandom_range(0, 33554431));
        if (pick < 60)
            return coord_t'(int'($urandom_range(0, 2097151)) - 1048576);
        else if (pick < 85)
            return coord_t'($urandom);
        else if (pick < 93)
            return coord_t'(COORD_MAX - off);
        else
            return coord_t'(COORD_MIN + off);
    endfunction

    function automatic arc_t random_arc();
        arc_t a;
        int   width;
        int   pick;
        a.cx = pick_coord();
        a.cy = pick_coord();

        // A random bit length spreads radii over every magnitude.
        width    = $urandom_range(0, RADIUS_W);
        a.radius = (width == 0) ? '0 : RADIUS_W'($urandom & ((32'd1 << width) - 1));

        pick = $urandom_range(0, 9);
        if (pick < 4)
            a.start = START_W'($urandom);
        else if (pick < 7)
            a.start = START_W'(int'($urandom_range(0, 8)) * QUARTER_TURN - FULL_TURN
                               + int'($urandom_range(0, 4)) - 2);
        else
            a.start = START_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);

        pick = $urandom_range(0, 99);
        if (pick < 12)
            a.span = '0;
        else if (pick < 24)
            a.span = SPAN_W'(FULL_TURN);
        else if (pick < 34)
            a.span = SPAN_W'($urandom_range(FULL_TURN + 1, (1 << SPAN_W) - 1));
        else if (pick < 50)
            a.span = SPAN_W'(int'($urandom_range(0, 4)) * QUARTER_TURN);
        else if (pick < 55)
            a.span = ($urandom_range(0, 1) != 0) ? SPAN_W'(1) : SPAN_W'(FULL_TURN - 1);
        else
            a.span = SPAN_W'($urandom_range(0, FULL_TURN));
        return a;
    endfunction

    // Offers one arc and returns once it has been taken. The sender works in
    // bursts: at the end of each burst it may leave the bus idle for a few
    // cycles, except while the long output stall is on, when it keeps
    // pushing so that the pipeline backs up to its input.
    task automatic offer_arc(input arc_t a, input bit known, input box_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (hold_on)
                gap = 0;
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;

        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        // span, start, radius, centre y, centre x from the top down; the
        // spare top bits are zero.
        s_axis_tdata  <= {a.span, a.start, a.radius, a.cy, a.cx};
        do
            @(posedge clk);
        while (!s_axis_tready);

        if (known)
            expected_boxes.push_back(want);
        else
            expected_boxes.push_back(arc_box(a));
        arcs_sent++;
        if (a.span == 0)
            zero_spans++;
        if (a.span >= FULL_TURN)
            full_circles++;
        if (a.span > FULL_TURN)
            clamped_spans++;
    endtask

    task automatic report_mismatch(input string what);
        // Printing stops after a while so a broken block cannot flood the
        // log; every mismatch is still counted.
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        box_t no_box;
        no_box = '{default: '0};

        // Degenerate arc at the origin.
        add_row(0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
        // Largest radius, full circle, centre on the positive rail: the
        // positive side saturates and the negative side is exactly the
        // centre less the radius.
        add_row(COORD_MAX, COORD_MAX, 16777215, 0, 360, 1'b1,
                COORD_MAX, 2130706432, 2130706432, COORD_MAX);
        // The same on the negative rail, starting at minus a full turn.
        add_row(COORD_MIN, COORD_MIN, 16777215, -360, 360, 1'b1,
                -2130706433, COORD_MIN, COORD_MIN, -2130706433);
        // Zero radius: the box collapses to the centre.
        add_row(12345, -6789, 0, 123, 200, 1'b1, -6789, 12345, -6789, 12345);
        // Most negative start with the largest span, clamped to a full turn.
        add_row(0, 0, 256, -512, 511, 1'b1, 256, -256, -256, 256);
        // Zero span at the 0 and 90 degree axes: the box is the start point.
        add_row(100, -100, 4096, 0, 0, 1'b1, -100, 4196, -100, 4196);
        add_row(0, 0, 4096, 90, 0, 1'b1, 4096, 0, 4096, 0);
        add_row(0, 0, 200, -360, 0, 1'b1, 0, 200, 0, 200);
        // Half turn whose endpoints sit on axis directions.
        add_row(0, 0, 4096, 180, 180, 1'b1, 0, -4096, -4096, 4096);
        // Span just beyond a full turn.
        add_row(0, 0, 100, 37, 361, 1'b1, 100, -100, -100, 100);
        // Largest start, which wraps, with zero span.
        add_row(5000, 7000, 3000, 511, 0, 1'b0);
        add_row(-2000, 3000, 1000, 45, 90, 1'b0);
        add_row(0, 0, 65536, -90, 180, 1'b0);
        add_row(0, 0, 16777215, 359, 1, 1'b0);
        add_row(0, 0, 16777215, 1, 359, 1'b0);
        add_row(2147000000, -2147000000, 9000000, 270, 180, 1'b0);
        // Tiny radii to probe the rounding of the offsets.
        add_row(0, 0, 1, 30, 0, 1'b0);
        add_row(0, 0, 3, 60, 0, 1'b0);
        add_row(0, 0, 255, -1, 2, 1'b0);
        add_row(-300, 400, 777, 360, 90, 1'b0);
        add_row(COORD_MIN, COORD_MAX, 16777215, 135, 90, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (arc_table[i])
            offer_arc(arc_table[i].arc, arc_table[i].known, arc_table[i].box);
        repeat (RANDOM_ARCS)
            offer_arc(random_arc(), 1'b0, no_box);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Let every pending box arrive, then wait out more than a full pipeline
        // depth so that any stray extra beat is caught.
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d arcs (%0d from the table, %0d random), %0d boxes checked.",
                 arcs_sent, arc_table.size(), arcs_sent - arc_table.size(), boxes_checked);
        $display("Spans: %0d full turns (%0d clamped), %0d zero; %s %0d cycles, %0d %s.",
                 full_circles, clamped_spans, zero_spans, "input held back",
                 input_stalls, held_stalls, "in the long stall");
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: changes its ready at the falling edge. Once enough arcs have
    // gone in it holds ready low for a long stretch, counted here, so that
    // all eight stages fill and the input side has to stall. After that it
    // cycles through stall patterns of random length.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_t mode;
        int       len;
        int       n;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && arcs_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_on   = 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
                hold_on = 1'b0;
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(8, 48);
            for (n = 0; n < len; n++)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:        m_axis_tready <= 1'b1;
                    RX_MOSTLY:      m_axis_tready <= ($urandom_range(0, 9) < 7);
                    RX_ONE_IN_FOUR: m_axis_tready <= (n % 4 == 3);
                    default:        m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every output beat is matched against the oldest pending box.
    // Fields sit in tdata as top, left, bottom, right from the lowest bit up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : box_check
        box_t got;
        box_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && !s_axis_tready)
            begin
                input_stalls++;
                if (hold_on)
                    held_stalls++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.top    = m_axis_tdata[0 +: COORD_W];
                got.left   = m_axis_tdata[COORD_W +: COORD_W];
                got.bottom = m_axis_tdata[2*COORD_W +: COORD_W];
                got.right  = m_axis_tdata[3*COORD_W +: COORD_W];
                if (expected_boxes.size() == 0)
                    report_mismatch($sformatf("box %0d %0d %0d %0d with no arc pending",
                                              got.top, got.left, got.bottom, got.right));
                else
                begin
                    want = expected_boxes.pop_front();
                    boxes_checked++;
                    if (got.top !== want.top)
                        report_mismatch($sformatf("box %0d top %0d, expected %0d",
                                                  boxes_checked, got.top, want.top));
                    if (got.left !== want.left)
                        report_mismatch($sformatf("box %0d left %0d, expected %0d",
                                                  boxes_checked, got.left, want.left));
                    if (got.bottom !== want.bottom)
                        report_mismatch($sformatf("box %0d bottom %0d, expected %0d",
                                                  boxes_checked, got.bottom, want.bottom));
                    if (got.right !== want.right)
                        report_mismatch($sformatf("box %0d right %0d, expected %0d",
                                                  boxes_checked, got.right, want.right));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts consecutive cycles in which no beat moves on either
    // side and stops the run once the limit is reached.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: %0d cycles without a beat, %0d boxes still pending.",
                 idle, expected_boxes.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/abb_pkg.sv
rtl/abb_coord.sv
rtl/arc_bounding_box.sv
test/tb.sv
